// ===== sv/ustc_pkg.sv =====
package ustc_pkg;

    localparam int XY_W  = 33;
    localparam int DIV_W = 63;
    localparam int REM_W = 32;
    localparam int ANG_TAB_LEN = 24;

    localparam logic signed [XY_W-1:0] CORDIC_K   = 33'sd652032875;
    localparam logic signed [33:0]     PI_Q30     = 34'sd3373259426;
    localparam logic signed [XY_W-1:0] QUARTER    = 33'sd1073741824;
    localparam logic signed [XY_W-1:0] HALF       = 33'sd2147483648;
    localparam logic signed [31:0]     SAT_MAX    = 32'sh7fffffff;
    localparam logic signed [31:0]     SAT_MIN    = 32'sh80000000;

    localparam logic REG_DAMPING   = 1'b0;
    localparam logic REG_BANDWIDTH = 1'b1;

    localparam logic signed [XY_W-1:0] ANG_TAB [ANG_TAB_LEN] = '{
        33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4,
        33'sh028B0D43, 33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55,
        33'sh0028BE53, 33'sh00145F2F, 33'sh000A2F98, 33'sh000517CC,
        33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA, 33'sh0000517D,
        33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
        33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
    };

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [15:0] ref_heading;
        logic signed [31:0] ref_speed;
        logic signed [31:0] ref_turn_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive_v;
        logic signed [31:0] steer_omega;
        logic               zero_speed_fault;
    } out_item_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } lane_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] zr;
        logic signed [32:0] zt;
        logic               flip_r;
        logic               flip_t;
        logic signed [16:0] dtheta;
        logic signed [31:0] vd;
        logic signed [31:0] wd;
        logic signed [31:0] k1;
        logic               neg_q;
        logic               fault;
    } div_side_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               flip_r;
        logic               flip_t;
        logic signed [16:0] dtheta;
        logic signed [31:0] vd;
        logic signed [31:0] wd;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic               fault;
    } cord_side_t;

    // fold into [-pi/2, pi/2], msb tells whether the result must be negated
    function automatic logic [XY_W:0] fold_angle(input logic signed [XY_W-1:0] z);
        logic signed [XY_W-1:0] r;
        logic                   f;
        r = z;
        f = 1'b0;
        if (z > QUARTER)
        begin
            r = z - HALF;
            f = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            r = z + HALF;
            f = 1'b1;
        end
        return {f, r};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = SAT_MAX;
        else if (v < -68'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/ustc_if.sv =====
interface ustc_in_if;
    logic                 valid;
    logic                 ready;
    ustc_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ustc_out_if;
    logic                 valid;
    logic                 ready;
    ustc_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/unicycle_tracking_controller.sv =====
// channel   | role   | payload
// pose      | sink   | robot pose, desired pose, ref_speed, ref_turn_rate
// cmd       | source | drive_v, steer_omega, zero_speed_fault
// apb       | slave  | damping at 0x0, bandwidth at 0x4
//
// one sample per cycle unless a held result stalls the pipeline; a result passes through
// seven plain stages, 63 divider cells and CORDIC_STEPS rotation cells to the output register
// rst_n clears the valid bits and loads damping 179 and bandwidth 256
// a result held in the output register stalls the whole pipeline until taken
module unicycle_tracking_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    ustc_in_if.sink      pose,
    ustc_out_if.source   cmd
);

    localparam int DIV_STEPS = ustc_pkg::DIV_W;
    localparam int DSW = $bits(ustc_pkg::div_side_t);
    localparam int CSW = $bits(ustc_pkg::cord_side_t);

    logic [15:0] damping_reg;
    logic [15:0] bandwidth_reg;
    logic        adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg   <= 16'd179;
            bandwidth_reg <= 16'd256;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                ustc_pkg::REG_DAMPING:   damping_reg   <= pwdata[15:0];
                ustc_pkg::REG_BANDWIDTH: bandwidth_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ustc_pkg::REG_DAMPING:   prdata = {16'b0, damping_reg};
            ustc_pkg::REG_BANDWIDTH: prdata = {16'b0, bandwidth_reg};
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic                out_valid_reg;
    ustc_pkg::out_item_t out_reg;

    assign adv        = !out_valid_reg || cmd.ready;
    assign pose.ready = adv;

    // stage 1: errors, heading wrap, angle folding, squares, k1
    logic [15:0]         dh_diff;
    logic signed [16:0]  dtheta_c;
    logic [33:0]         fold_r;
    logic [33:0]         fold_t;
    logic signed [63:0]  wsq_c;
    logic [31:0]         dbw_c;
    ustc_pkg::div_side_t s1_side_c;

    always_comb
    begin
        dh_diff  = pose.data.ref_heading - pose.data.robot_heading;
        dtheta_c = (dh_diff == 16'h8000) ? 17'sd32768 : {dh_diff[15], dh_diff};
        fold_r   = ustc_pkg::fold_angle({pose.data.robot_heading[15],
                                         pose.data.robot_heading, 16'b0});
        fold_t   = ustc_pkg::fold_angle({dtheta_c, 16'b0});
        wsq_c    = pose.data.ref_turn_rate * pose.data.ref_turn_rate;
        dbw_c    = damping_reg * bandwidth_reg;
        s1_side_c.dx     = 33'(pose.data.ref_x) - 33'(pose.data.robot_x);
        s1_side_c.dy     = 33'(pose.data.ref_y) - 33'(pose.data.robot_y);
        s1_side_c.zr     = fold_r[32:0];
        s1_side_c.zt     = fold_t[32:0];
        s1_side_c.flip_r = fold_r[33];
        s1_side_c.flip_t = fold_t[33];
        s1_side_c.dtheta = dtheta_c;
        s1_side_c.vd     = pose.data.ref_speed;
        s1_side_c.wd     = pose.data.ref_turn_rate;
        s1_side_c.k1     = (dbw_c[31:30] != 2'b00) ? ustc_pkg::SAT_MAX
                                                    : {dbw_c[30:0], 1'b0};
        s1_side_c.neg_q  = 1'b0;
        s1_side_c.fault  = (pose.data.ref_speed == 32'sd0);
    end

    logic                s1_valid_reg;
    ustc_pkg::div_side_t s1_side_reg;
    logic [62:0]         s1_wsq_reg;
    logic [31:0]         s1_a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= pose.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= s1_side_c;
            s1_wsq_reg  <= wsq_c[62:0];
            s1_a2_reg   <= bandwidth_reg * bandwidth_reg;
        end
    end

    // stage 2: numerator and divisor magnitudes
    logic signed [63:0]  num_c;
    logic [62:0]         nmag_c;
    logic [31:0]         dvmag_c;
    ustc_pkg::div_side_t s2_side_c;

    always_comb
    begin
        num_c     = $signed({16'b0, s1_a2_reg, 16'b0}) - $signed({1'b0, s1_wsq_reg});
        nmag_c    = num_c[63] ? 63'(-num_c) : num_c[62:0];
        dvmag_c   = s1_side_reg.vd[31] ? 32'(-s1_side_reg.vd) : 32'(s1_side_reg.vd);
        s2_side_c = s1_side_reg;
        s2_side_c.neg_q = num_c[63] ^ s1_side_reg.vd[31];
    end

    logic                       dvalid [0:DIV_STEPS];
    logic [ustc_pkg::REM_W-1:0] drem   [0:DIV_STEPS];
    logic [ustc_pkg::DIV_W-1:0] dquo   [0:DIV_STEPS];
    logic [ustc_pkg::REM_W-1:0] ddv    [0:DIV_STEPS];
    logic [DSW-1:0]             dside  [0:DIV_STEPS];

    logic                       s2_valid_reg;
    logic [ustc_pkg::DIV_W-1:0] s2_quo_reg;
    logic [ustc_pkg::REM_W-1:0] s2_dv_reg;
    ustc_pkg::div_side_t        s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_quo_reg  <= nmag_c;
            s2_dv_reg   <= dvmag_c;
            s2_side_reg <= s2_side_c;
        end
    end

    assign dvalid[0] = s2_valid_reg;
    assign drem[0]   = '0;
    assign dquo[0]   = s2_quo_reg;
    assign ddv[0]    = s2_dv_reg;
    assign dside[0]  = s2_side_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ustc_div_cell #(.SIDE_W(DSW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dvalid[i]),
            .in_rem    (drem[i]),
            .in_quo    (dquo[i]),
            .in_dv     (ddv[i]),
            .in_side   (dside[i]),
            .out_valid (dvalid[i+1]),
            .out_rem   (drem[i+1]),
            .out_quo   (dquo[i+1]),
            .out_dv    (ddv[i+1]),
            .out_side  (dside[i+1])
        );
    end

    // stage 3: sign and saturate k2, set up the rotators
    ustc_pkg::div_side_t  dend;
    logic [62:0]          q;
    logic signed [31:0]   k2_c;
    ustc_pkg::cord_side_t s3_side_c;

    always_comb
    begin
        dend = ustc_pkg::div_side_t'(dside[DIV_STEPS]);
        q    = dquo[DIV_STEPS];
        if (dend.fault)
            k2_c = 32'sd0;
        else if (dend.neg_q)
            k2_c = (q > 63'd2147483648) ? ustc_pkg::SAT_MIN : 32'(-q[31:0]);
        else
            k2_c = (q > 63'd2147483647) ? ustc_pkg::SAT_MAX : q[31:0];
        s3_side_c.dx     = dend.dx;
        s3_side_c.dy     = dend.dy;
        s3_side_c.flip_r = dend.flip_r;
        s3_side_c.flip_t = dend.flip_t;
        s3_side_c.dtheta = dend.dtheta;
        s3_side_c.vd     = dend.vd;
        s3_side_c.wd     = dend.wd;
        s3_side_c.k1     = dend.k1;
        s3_side_c.k2     = k2_c;
        s3_side_c.fault  = dend.fault;
    end

    logic                 s3_valid_reg;
    ustc_pkg::cord_side_t s3_side_reg;
    logic signed [32:0]   s3_zr_reg;
    logic signed [32:0]   s3_zt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= dvalid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s3_side_c;
            s3_zr_reg   <= dend.zr;
            s3_zt_reg   <= dend.zt;
        end
    end

    logic            cvalid [0:CORDIC_STEPS];
    ustc_pkg::lane_t ca     [0:CORDIC_STEPS];
    ustc_pkg::lane_t cb     [0:CORDIC_STEPS];
    logic [CSW-1:0]  cside  [0:CORDIC_STEPS];

    assign cvalid[0] = s3_valid_reg;
    assign ca[0]     = '{x: ustc_pkg::CORDIC_K, y: '0, z: s3_zr_reg};
    assign cb[0]     = '{x: ustc_pkg::CORDIC_K, y: '0, z: s3_zt_reg};
    assign cside[0]  = s3_side_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        ustc_cordic_cell #(.STEP(i), .SIDE_W(CSW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cvalid[i]),
            .in_a      (ca[i]),
            .in_b      (cb[i]),
            .in_side   (cside[i]),
            .out_valid (cvalid[i+1]),
            .out_a     (ca[i+1]),
            .out_b     (cb[i+1]),
            .out_side  (cside[i+1])
        );
    end

    // stage 4: undo the fold, rotate the error into the robot frame
    ustc_pkg::cord_side_t cend;
    logic signed [32:0]   c_c;
    logic signed [32:0]   s_c;
    logic signed [32:0]   c3_c;
    logic signed [50:0]   e3p_c;
    logic signed [50:0]   e3r_c;

    always_comb
    begin
        cend  = ustc_pkg::cord_side_t'(cside[CORDIC_STEPS]);
        c_c   = cend.flip_r ? -ca[CORDIC_STEPS].x : ca[CORDIC_STEPS].x;
        s_c   = cend.flip_r ? -ca[CORDIC_STEPS].y : ca[CORDIC_STEPS].y;
        c3_c  = cend.flip_t ? -cb[CORDIC_STEPS].x : cb[CORDIC_STEPS].x;
        e3p_c = cend.dtheta * ustc_pkg::PI_Q30;
        e3r_c = (e3p_c + 51'sd268435456) >>> 29;
    end

    logic               s4_valid_reg;
    logic signed [65:0] p_cdx_reg;
    logic signed [65:0] p_sdy_reg;
    logic signed [65:0] p_cdy_reg;
    logic signed [65:0] p_sdx_reg;
    logic signed [64:0] p_vc_reg;
    logic signed [31:0] s4_e3_reg;
    logic signed [31:0] s4_wd_reg;
    logic signed [31:0] s4_k1_reg;
    logic signed [31:0] s4_k2_reg;
    logic               s4_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= cvalid[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cdx_reg    <= c_c * cend.dx;
            p_sdy_reg    <= s_c * cend.dy;
            p_cdy_reg    <= c_c * cend.dy;
            p_sdx_reg    <= s_c * cend.dx;
            p_vc_reg     <= cend.vd * c3_c;
            s4_e3_reg    <= e3r_c[31:0];
            s4_wd_reg    <= cend.wd;
            s4_k1_reg    <= cend.k1;
            s4_k2_reg    <= cend.k2;
            s4_fault_reg <= cend.fault;
        end
    end

    // stage 5: round the products, e1 and e2 saturate
    localparam logic signed [66:0] HALF30 = 67'sd536870912;
    logic signed [66:0] r_cdx;
    logic signed [66:0] r_sdy;
    logic signed [66:0] r_cdy;
    logic signed [66:0] r_sdx;
    logic signed [66:0] r_vc;

    always_comb
    begin
        r_cdx = (67'(p_cdx_reg) + HALF30) >>> 30;
        r_sdy = (67'(p_sdy_reg) + HALF30) >>> 30;
        r_cdy = (67'(p_cdy_reg) + HALF30) >>> 30;
        r_sdx = (67'(p_sdx_reg) + HALF30) >>> 30;
        r_vc  = (67'(p_vc_reg) + HALF30) >>> 30;
    end

    logic               s5_valid_reg;
    logic signed [31:0] e1_reg;
    logic signed [31:0] e2_reg;
    logic signed [31:0] s5_e3_reg;
    logic signed [35:0] vc_reg;
    logic signed [31:0] s5_wd_reg;
    logic signed [31:0] s5_k1_reg;
    logic signed [31:0] s5_k2_reg;
    logic               s5_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg       <= ustc_pkg::sat32(68'(r_cdx + r_sdy));
            e2_reg       <= ustc_pkg::sat32(68'(r_cdy - r_sdx));
            s5_e3_reg    <= s4_e3_reg;
            vc_reg       <= r_vc[35:0];
            s5_wd_reg    <= s4_wd_reg;
            s5_k1_reg    <= s4_k1_reg;
            s5_k2_reg    <= s4_k2_reg;
            s5_fault_reg <= s4_fault_reg;
        end
    end

    // stage 6: gain products
    logic               s6_valid_reg;
    logic signed [63:0] m1_reg;
    logic signed [63:0] m2_reg;
    logic signed [63:0] m3_reg;
    logic signed [35:0] s6_vc_reg;
    logic signed [31:0] s6_wd_reg;
    logic               s6_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg       <= s5_k1_reg * e1_reg;
            m2_reg       <= s5_k2_reg * e2_reg;
            m3_reg       <= s5_k1_reg * s5_e3_reg;
            s6_vc_reg    <= vc_reg;
            s6_wd_reg    <= s5_wd_reg;
            s6_fault_reg <= s5_fault_reg;
        end
    end

    // stage 7: final sums into the output register
    localparam logic signed [67:0] HALF16 = 68'sd32768;
    logic signed [67:0]  q1;
    logic signed [67:0]  q2;
    logic signed [67:0]  q3;
    ustc_pkg::out_item_t out_c;

    always_comb
    begin
        q1 = (68'(m1_reg) + HALF16) >>> 16;
        q2 = (68'(m2_reg) + HALF16) >>> 16;
        q3 = (68'(m3_reg) + HALF16) >>> 16;
        out_c.drive_v          = ustc_pkg::sat32(68'(s6_vc_reg) + q1);
        out_c.steer_omega      = ustc_pkg::sat32(68'(s6_wd_reg) + q2 + q3);
        out_c.zero_speed_fault = s6_fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_c;
    end

    assign cmd.valid = out_valid_reg;
    assign cmd.data  = out_reg;

endmodule

// ===== sv/ustc_div_cell.sv =====
module ustc_div_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [ustc_pkg::REM_W-1:0]  in_rem,
    input  logic [ustc_pkg::DIV_W-1:0]  in_quo,
    input  logic [ustc_pkg::REM_W-1:0]  in_dv,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [ustc_pkg::REM_W-1:0]  out_rem,
    output logic [ustc_pkg::DIV_W-1:0]  out_quo,
    output logic [ustc_pkg::REM_W-1:0]  out_dv,
    output logic [SIDE_W-1:0]           out_side
);

    logic                        valid_reg;
    logic [ustc_pkg::REM_W-1:0]  rem_reg;
    logic [ustc_pkg::REM_W-1:0]  rem_next;
    logic [ustc_pkg::DIV_W-1:0]  quo_reg;
    logic [ustc_pkg::DIV_W-1:0]  quo_next;
    logic [ustc_pkg::REM_W-1:0]  dv_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic [ustc_pkg::REM_W:0]    trial;
    logic [ustc_pkg::REM_W:0]    diff;
    logic                        take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {in_rem, in_quo[ustc_pkg::DIV_W-1]};
        diff     = trial - {1'b0, in_dv};
        take     = (trial >= {1'b0, in_dv});
        rem_next = take ? diff[ustc_pkg::REM_W-1:0] : trial[ustc_pkg::REM_W-1:0];
        quo_next = {in_quo[ustc_pkg::DIV_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dv_reg   <= in_dv;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dv    = dv_reg;
    assign out_side  = side_reg;

endmodule

// ===== sv/ustc_cordic_cell.sv =====
module ustc_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  ustc_pkg::lane_t        in_a,
    input  ustc_pkg::lane_t        in_b,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output ustc_pkg::lane_t        out_a,
    output ustc_pkg::lane_t        out_b,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg;
    ustc_pkg::lane_t   a_reg;
    ustc_pkg::lane_t   a_next;
    ustc_pkg::lane_t   b_reg;
    ustc_pkg::lane_t   b_next;
    logic [SIDE_W-1:0] side_reg;

    function automatic ustc_pkg::lane_t rotate(input ustc_pkg::lane_t l);
        ustc_pkg::lane_t r;
        if (l.z >= 0)
        begin
            r.x = l.x - (l.y >>> STEP);
            r.y = l.y + (l.x >>> STEP);
            r.z = l.z - ustc_pkg::ANG_TAB[STEP];
        end
        else
        begin
            r.x = l.x + (l.y >>> STEP);
            r.y = l.y - (l.x >>> STEP);
            r.z = l.z + ustc_pkg::ANG_TAB[STEP];
        end
        return r;
    endfunction

    always_comb
    begin
        a_next = rotate(in_a);
        b_next = rotate(in_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_side  = side_reg;

endmodule

// ===== tb/sv/tb_unicycle_tracking_controller.sv =====
`timescale 1ns / 100ps

module tb_unicycle_tracking_controller;

    localparam int  NUM_STEPS      = 16;
    localparam int  PIPE_LATENCY   = 73 + NUM_STEPS;
    localparam int  CYCLE_LIMIT    = 600000;
    localparam int  RANDOM_ITEMS   = 1900;
    localparam logic [2:0] ADDR_DAMPING   = 3'd0;
    localparam logic [2:0] ADDR_BANDWIDTH = 3'd4;
    localparam longint RAD_PI_Q30  = 64'sd3373259426;
    localparam longint GAIN_Q30    = 64'sd652032875;

    class cmd_scoreboard;
        ustc_pkg::out_item_t pending_cmds[$];
        longint    damping;
        longint    bandwidth;
        int        mismatches;
        int        notes;

        function new();
            damping    = 179;
            bandwidth  = 256;
            mismatches = 0;
            notes      = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        // rotation-mode cordic, angle with pi = 2^31, outputs Q2.30
        function void sin_cos(longint ang, output longint co, output longint si);
            longint atan_tab[16] = '{
                64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
            longint x;
            longint y;
            longint nx;
            longint z;
            bit     flip;
            x = GAIN_Q30;
            y = 0;
            z = ang;
            flip = 0;
            if (z > (64'sd1 <<< 30))
            begin
                z -= (64'sd1 <<< 31);
                flip = 1;
            end
            else if (z < -(64'sd1 <<< 30))
            begin
                z += (64'sd1 <<< 31);
                flip = 1;
            end
            for (int i = 0; i < NUM_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z -= atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z += atan_tab[i];
                end
                x = nx;
            end
            co = flip ? -x : x;
            si = flip ? -y : y;
        endfunction

        function ustc_pkg::out_item_t predict_cmd(ustc_pkg::in_item_t s);
            ustc_pkg::out_item_t r;
            longint dx, dy, dth, c, sn, c3, s3, e1, e2, e3, k1, k2, num, v, w;
            logic signed [15:0] dh16;
            dx   = longint'(s.ref_x) - longint'(s.robot_x);
            dy   = longint'(s.ref_y) - longint'(s.robot_y);
            dh16 = s.ref_heading - s.robot_heading;
            dth  = longint'(dh16);
            // -pi is folded onto +pi
            if (dth == -32768)
                dth = 32768;
            sin_cos(longint'(s.robot_heading) * 65536, c, sn);
            sin_cos(dth * 65536, c3, s3);
            e1 = clamp32(round_shift(c * dx, 30) + round_shift(sn * dy, 30));
            e2 = clamp32(round_shift(c * dy, 30) - round_shift(sn * dx, 30));
            e3 = round_shift(dth * RAD_PI_Q30, 29);
            k1 = clamp32(2 * damping * bandwidth);
            k2 = 0;
            r.zero_speed_fault = 1'b0;
            if (s.ref_speed == 0)
                r.zero_speed_fault = 1'b1;
            else
            begin
                num = bandwidth * bandwidth * 65536
                    - longint'(s.ref_turn_rate) * longint'(s.ref_turn_rate);
                k2 = clamp32(num / longint'(s.ref_speed));
            end
            v = clamp32(round_shift(longint'(s.ref_speed) * c3, 30)
                        + round_shift(k1 * e1, 16));
            w = clamp32(longint'(s.ref_turn_rate) + round_shift(k2 * e2, 16)
                        + round_shift(k1 * e3, 16));
            r.drive_v     = v[31:0];
            r.steer_omega = w[31:0];
            return r;
        endfunction

        function void note_sample(ustc_pkg::in_item_t s);
            pending_cmds.push_back(predict_cmd(s));
            notes++;
        endfunction

        function void check_cmd(ustc_pkg::out_item_t got);
            ustc_pkg::out_item_t want;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cmd transfer: v=%0d w=%0d f=%0b",
                             got.drive_v, got.steer_omega, got.zero_speed_fault);
                return;
            end
            want = pending_cmds.pop_front();
            if (got.drive_v !== want.drive_v || got.steer_omega !== want.steer_omega
                || got.zero_speed_fault !== want.zero_speed_fault)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cmd mismatch: exp v=%0d w=%0d f=%0b got v=%0d w=%0d f=%0b",
                             want.drive_v, want.steer_omega, want.zero_speed_fault,
                             got.drive_v, got.steer_omega, got.zero_speed_fault);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ustc_in_if  pose();
    ustc_out_if cmd();

    cmd_scoreboard sb = new();
    int  cycles;
    bit  hold_done;

    unicycle_tracking_controller #(.CORDIC_STEPS(NUM_STEPS)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pose    (pose.sink),
        .cmd     (cmd.source)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
            sb.check_cmd(cmd.data);
    end

    // receiver: changing stall pattern plus one long hold-off
    initial
    begin
        int pattern;
        int left;
        int hold;
        pattern   = 0;
        left      = 0;
        hold      = 0;
        hold_done = 0;
        cmd.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.notes >= 400)
            begin
                hold_done = 1;
                hold = 600;
            end
            if (left == 0)
            begin
                pattern = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (hold > 0)
            begin
                hold--;
                cmd.ready <= 1'b0;
            end
            else
                case (pattern)
                    0: cmd.ready <= 1'b1;
                    1: cmd.ready <= 1'($urandom_range(0, 1));
                    2: cmd.ready <= ($urandom_range(0, 7) == 0);
                    default: cmd.ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    task automatic wait_drained();
        while (sb.pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_gains(input logic [15:0] zeta, input logic [15:0] a);
        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        apb_write(ADDR_DAMPING, {16'h0, zeta});
        apb_write(ADDR_BANDWIDTH, {16'h0, a});
        sb.damping   = longint'(zeta);
        sb.bandwidth = longint'(a);
    endtask

    int burst_left;

    task automatic send_sample(input ustc_pkg::in_item_t s);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                pose.valid <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        pose.valid <= 1'b1;
        pose.data  <= s;
        @(posedge clk);
        while (!pose.ready)
            @(posedge clk);
        sb.note_sample(s);
    endtask

    function automatic ustc_pkg::in_item_t random_sample();
        ustc_pkg::in_item_t s;
        int mode;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        mode = $urandom_range(0, 9);
        s.robot_x       = $urandom;
        s.robot_y       = $urandom;
        s.robot_heading = 16'($urandom);
        s.ref_x         = $urandom;
        s.ref_y         = $urandom;
        s.ref_heading   = 16'($urandom);
        s.ref_speed     = $urandom;
        s.ref_turn_rate = $urandom;
        if (mode >= 3)
        begin
            // plausible tracking sample near a common point
            bx = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            by = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            s.robot_x       = bx;
            s.robot_y       = by;
            s.ref_x         = bx + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            s.ref_y         = by + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            s.ref_speed     = $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            s.ref_turn_rate = $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            if ($urandom_range(0, 3) == 0)
                s.ref_heading = 16'(s.robot_heading + $signed($urandom_range(0, 2047))
                                    - 1024);
        end
        if ($urandom_range(0, 15) == 0)
            s.ref_speed = 0;
        return s;
    endfunction

    task automatic run_directed();
        ustc_pkg::in_item_t s;
        for (int k = 0; k < 20; k++)
        begin
            s = '0;
            case (k)
                1:
                begin
                    s.robot_x = 32'sh80000000;
                    s.robot_y = 32'sh80000000;
                    s.ref_x = 32'sh7fffffff;
                    s.ref_y = 32'sh7fffffff;
                    s.ref_speed = 32'sh7fffffff;
                    s.ref_turn_rate = 32'sh7fffffff;
                end
                2:
                begin
                    s.robot_x = 32'sh7fffffff;
                    s.robot_y = 32'sh7fffffff;
                    s.ref_x = 32'sh80000000;
                    s.ref_y = 32'sh80000000;
                    s.ref_speed = 32'sh80000000;
                    s.ref_turn_rate = 32'sh80000000;
                end
                // heading difference landing on -pi
                3:
                begin
                    s.robot_heading = 16'sh7fff;
                    s.ref_heading = -16'sh0001;
                    s.ref_speed = 32'sh10000;
                end
                4:
                begin
                    s.robot_heading = 16'sh8000;
                    s.ref_heading = 16'sh0000;
                    s.ref_speed = 32'sh10000;
                end
                5:
                begin
                    s.robot_heading = 16'sh4000;
                    s.ref_heading = -16'sh4000;
                    s.ref_x = 32'sh30000;
                    s.ref_speed = -32'sh10000;
                end
                6: s.ref_speed = 32'sh1;
                7: s.ref_speed = -32'sh1;
                8:
                begin
                    s.ref_speed = 0;
                    s.ref_turn_rate = 32'sh7fffffff;
                    s.ref_y = 32'sh10000;
                end
                9:
                begin
                    s.ref_speed = 0;
                    s.ref_turn_rate = 32'sh80000000;
                    s.ref_heading = 16'sh8000;
                end
                10:
                begin
                    s.robot_heading = 16'sh7fff;
                    s.ref_heading = 16'sh7fff;
                    s.ref_x = 32'sh7fffffff;
                    s.ref_speed = 32'sh8000;
                end
                11:
                begin
                    s.robot_heading = 16'shc000;
                    s.ref_heading = 16'sh4000;
                    s.ref_y = -32'sh50000;
                    s.ref_speed = 32'sh20000;
                    s.ref_turn_rate = 32'sh18000;
                end
                default: s = random_sample();
            endcase
            send_sample(s);
        end
    endtask

    initial
    begin
        logic [15:0] zetas [6] = '{16'd179, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'd512};
        logic [15:0] bws   [6] = '{16'd256, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd128};
        burst_left = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        pose.valid = 1'b0;
        pose.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                @(negedge clk);
                pose.valid <= 1'b0;
                if (ph < 6)
                    set_gains(zetas[ph], bws[ph]);
                else
                    set_gains(16'($urandom), 16'($urandom_range(0, 1024)));
            end
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
                send_sample(random_sample());
        end
        @(negedge clk);
        pose.valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
